// ----- src/inv_pkg.sv -----
package inv_pkg;

   // Character codes the checker looks for.
   localparam logic [7:0] CHAR_DASH       = 8'h2d;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7a;
   localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;

   // Fewest characters a name part may hold.
   localparam int MIN_NAME_LEN = 2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MAX_NAME_LEN  = 2'd0;
   localparam logic [1:0] CSR_MAX_KEY_LEN   = 2'd1;
   localparam logic [1:0] CSR_MAX_TOTAL_LEN = 2'd2;

   typedef enum logic [1:0] {
      PHASE_NAME  = 2'd0,
      PHASE_KEY   = 2'd1,
      PHASE_EXTRA = 2'd2
   } phase_type;

   typedef enum logic [3:0] {
      ST_OK               = 4'd0,
      ST_TOO_LONG         = 4'd1,
      ST_EXTRA_UNDERSCORE = 4'd2,
      ST_LEAD_DASH        = 4'd3,
      ST_TRAIL_DASH       = 4'd4,
      ST_DOUBLE_DASH      = 4'd5,
      ST_BAD_CHAR         = 4'd6,
      ST_NO_LETTER        = 4'd7,
      ST_SHORT            = 4'd8,
      ST_NAME_LONG        = 4'd9,
      ST_KEY_CHAR         = 4'd10,
      ST_KEY_EMPTY        = 4'd11,
      ST_KEY_LONG         = 4'd12
   } status_type;

   // One classified item as it travels from the front to the back.
   typedef struct packed {
      logic has_char;
      logic last;
      logic is_lower;
      logic is_digit;
      logic is_dash;
      logic is_underscore;
   } item_type;

   // Limits held in the configuration registers.
   typedef struct packed {
      logic [5:0] max_name_len;
      logic [5:0] max_key_len;
      logic [6:0] max_total_len;
   } cfg_type;

endpackage

// ----- src/inv_front.sv -----
module inv_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_character,
   input  logic              req_has_char,
   input  logic              req_last,
   output logic              push,
   output inv_pkg::item_type push_item,
   input  logic              queue_full
);

   logic              valid_ff, valid_in;
   inv_pkg::item_type item_ff, item_in;

   // Classify the incoming byte.
   always_comb begin
      item_in.has_char      = req_has_char;
      item_in.last          = req_last;
      item_in.is_lower      = (req_character >= inv_pkg::CHAR_LOWER_A) &&
                              (req_character <= inv_pkg::CHAR_LOWER_Z);
      item_in.is_digit      = (req_character >= inv_pkg::CHAR_DIGIT_0) &&
                              (req_character <= inv_pkg::CHAR_DIGIT_9);
      item_in.is_dash       = (req_character == inv_pkg::CHAR_DASH);
      item_in.is_underscore = (req_character == inv_pkg::CHAR_UNDERSCORE);
   end

   // The stage holds while the queue is full; an item with no byte that
   // does not end the identifier has no effect and is dropped here.
   assign req_stall = valid_ff && queue_full;
   assign push      = valid_ff && !queue_full;
   assign push_item = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (!req_stall) begin
         valid_in = req_valid && (req_has_char || req_last);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (!req_stall) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- src/inv_queue.sv -----
module inv_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  inv_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output inv_pkg::item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   inv_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- src/inv_back.sv -----
module inv_back #(
   parameter int COUNT_BITS = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  inv_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  inv_pkg::item_type item,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_status
);

   localparam int CMP_W = (COUNT_BITS > 7) ? COUNT_BITS : 7;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] MIN_NAME = COUNT_BITS'(inv_pkg::MIN_NAME_LEN);

   inv_pkg::phase_type  phase_ff, phase_in, phase_nx;
   logic [COUNT_BITS-1:0] total_ff, total_in, total_nx;
   logic [COUNT_BITS-1:0] name_ff, name_in, name_nx;
   logic [COUNT_BITS-1:0] key_ff, key_in, key_nx;
   logic                seen_letter_ff, seen_letter_in, seen_letter_nx;
   logic                prev_dash_ff, prev_dash_in, prev_dash_nx;
   inv_pkg::status_type name_err_ff, name_err_in, name_err_nx, name_err_end;
   logic                key_bad_ff, key_bad_in, key_bad_nx;
   logic                rsp_valid_ff, rsp_valid_in;
   inv_pkg::status_type rsp_status_ff, rsp_status_in, status;
   logic                out_free;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   // A non-final item always proceeds; a final one needs the output register.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = item_valid && (!item.last || out_free);

   // Per-byte update of counters and flags.
   always_comb begin
      phase_nx       = phase_ff;
      total_nx       = total_ff;
      name_nx        = name_ff;
      key_nx         = key_ff;
      seen_letter_nx = seen_letter_ff;
      prev_dash_nx   = prev_dash_ff;
      name_err_nx    = name_err_ff;
      key_bad_nx     = key_bad_ff;
      if (item.has_char) begin
         total_nx = sat_inc(total_ff);
         if (item.is_underscore) begin
            if (phase_ff == inv_pkg::PHASE_NAME) begin
               if (prev_dash_ff && name_err_ff == inv_pkg::ST_OK) begin
                  name_err_nx = inv_pkg::ST_TRAIL_DASH;
               end
               prev_dash_nx = 1'b0;
               phase_nx     = inv_pkg::PHASE_KEY;
            end else begin
               phase_nx = inv_pkg::PHASE_EXTRA;
            end
         end else begin
            case (phase_ff)
               inv_pkg::PHASE_NAME: begin
                  if (item.is_dash) begin
                     if (name_err_ff == inv_pkg::ST_OK) begin
                        if (name_ff == '0) begin
                           name_err_nx = inv_pkg::ST_LEAD_DASH;
                        end else if (prev_dash_ff) begin
                           name_err_nx = inv_pkg::ST_DOUBLE_DASH;
                        end
                     end
                     prev_dash_nx = 1'b1;
                  end else begin
                     if (item.is_lower) begin
                        seen_letter_nx = 1'b1;
                     end else if (!item.is_digit && name_err_ff == inv_pkg::ST_OK) begin
                        name_err_nx = inv_pkg::ST_BAD_CHAR;
                     end
                     prev_dash_nx = 1'b0;
                  end
                  name_nx = sat_inc(name_ff);
               end
               inv_pkg::PHASE_KEY: begin
                  if (!item.is_lower && !item.is_digit) begin
                     key_bad_nx = 1'b1;
                  end
                  key_nx = sat_inc(key_ff);
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Final status in priority order, taken from the updated state.
   always_comb begin
      name_err_end = name_err_nx;
      if (phase_nx == inv_pkg::PHASE_NAME && prev_dash_nx &&
          name_err_nx == inv_pkg::ST_OK) begin
         name_err_end = inv_pkg::ST_TRAIL_DASH;
      end
      if (CMP_W'(total_nx) > CMP_W'(cfg.max_total_len)) begin
         status = inv_pkg::ST_TOO_LONG;
      end else if (phase_nx == inv_pkg::PHASE_EXTRA) begin
         status = inv_pkg::ST_EXTRA_UNDERSCORE;
      end else if (name_err_end != inv_pkg::ST_OK) begin
         status = name_err_end;
      end else if (!seen_letter_nx) begin
         status = inv_pkg::ST_NO_LETTER;
      end else if (name_nx < MIN_NAME) begin
         status = inv_pkg::ST_SHORT;
      end else if (CMP_W'(name_nx) > CMP_W'(cfg.max_name_len)) begin
         status = inv_pkg::ST_NAME_LONG;
      end else if (phase_nx == inv_pkg::PHASE_KEY && key_bad_nx) begin
         status = inv_pkg::ST_KEY_CHAR;
      end else if (phase_nx == inv_pkg::PHASE_KEY && key_nx == '0) begin
         status = inv_pkg::ST_KEY_EMPTY;
      end else if (phase_nx == inv_pkg::PHASE_KEY &&
                   CMP_W'(key_nx) > CMP_W'(cfg.max_key_len)) begin
         status = inv_pkg::ST_KEY_LONG;
      end else begin
         status = inv_pkg::ST_OK;
      end
   end

   // State commit: the end of an identifier returns everything to zero.
   always_comb begin
      phase_in       = phase_ff;
      total_in       = total_ff;
      name_in        = name_ff;
      key_in         = key_ff;
      seen_letter_in = seen_letter_ff;
      prev_dash_in   = prev_dash_ff;
      name_err_in    = name_err_ff;
      key_bad_in     = key_bad_ff;
      if (pop) begin
         if (item.last) begin
            phase_in       = inv_pkg::PHASE_NAME;
            total_in       = '0;
            name_in        = '0;
            key_in         = '0;
            seen_letter_in = 1'b0;
            prev_dash_in   = 1'b0;
            name_err_in    = inv_pkg::ST_OK;
            key_bad_in     = 1'b0;
         end else begin
            phase_in       = phase_nx;
            total_in       = total_nx;
            name_in        = name_nx;
            key_in         = key_nx;
            seen_letter_in = seen_letter_nx;
            prev_dash_in   = prev_dash_nx;
            name_err_in    = name_err_nx;
            key_bad_in     = key_bad_nx;
         end
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      if (out_free) begin
         rsp_valid_in  = pop && item.last;
         rsp_status_in = status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= inv_pkg::PHASE_NAME;
         total_ff       <= '0;
         name_ff        <= '0;
         key_ff         <= '0;
         seen_letter_ff <= 1'b0;
         prev_dash_ff   <= 1'b0;
         name_err_ff    <= inv_pkg::ST_OK;
         key_bad_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         total_ff       <= total_in;
         name_ff        <= name_in;
         key_ff         <= key_in;
         seen_letter_ff <= seen_letter_in;
         prev_dash_ff   <= prev_dash_in;
         name_err_ff    <= name_err_in;
         key_bad_ff     <= key_bad_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ----- src/instance_name_validator_top.sv -----
// Identifier checker. Bytes of one identifier enter on the req_ channel, one
// item per byte, with req_last on the final item; an empty identifier is a
// single item with req_has_char low and req_last high. Items with neither a
// byte nor last are dropped. Each identifier gives one status on the rsp_
// channel when its last item has been processed.
// The front stage classifies each byte and places it in a short queue; the
// back stage updates the counters and flags and forms the status in its
// output register. A last item passes the front register and a queue entry
// before its status is registered. The block takes one item every cycle
// when nothing stalls; the back stage's per-byte state update sets it.
// When rsp_stall is high the waiting status holds, the back stage keeps
// taking non-final items, and req_stall rises once the queue and the front
// stage are full.
// The csr_ channel is always ready; limits may be written only while idle.
// Reset clears the queue, the counters and flags, and restores the limits
// to 40 for the name, 10 for the key and 51 for the whole identifier.
module instance_name_validator_top #(
   parameter int COUNT_BITS  = 7,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_character,
   input  logic       req_has_char,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_status,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_data
);

   inv_pkg::cfg_type  cfg_ff, cfg_in;
   logic              push, queue_full, pop, queue_not_empty;
   inv_pkg::item_type push_item, pop_item;

   // Configuration registers; unknown indexes are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            inv_pkg::CSR_MAX_NAME_LEN:  cfg_in.max_name_len  = csr_data[5:0];
            inv_pkg::CSR_MAX_KEY_LEN:   cfg_in.max_key_len   = csr_data[5:0];
            inv_pkg::CSR_MAX_TOTAL_LEN: cfg_in.max_total_len = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_name_len  <= 6'd40;
         cfg_ff.max_key_len   <= 6'd10;
         cfg_ff.max_total_len <= 7'd51;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   inv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_character (req_character),
      .req_has_char  (req_has_char),
      .req_last      (req_last),
      .push          (push),
      .push_item     (push_item),
      .queue_full    (queue_full)
   );

   inv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_item  (pop_item)
   );

   inv_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (queue_not_empty),
      .item       (pop_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status)
   );

endmodule
